### src/jrd_pkg.sv
package jrd_pkg;

    // Field widths and fixed-point scale
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] ONE_Q   = SAMPLE_BITS'(1) << FRAC_BITS;
    localparam logic [SAMPLE_BITS-1:0] MAX_POS = ONE_Q - SAMPLE_BITS'(1);

    // Pipeline geometry
    localparam int SQRT_STAGES = SAMPLE_BITS;
    localparam int DIV_STAGES  = SAMPLE_BITS;
    localparam int PIPE_DEPTH  = 2 + SQRT_STAGES + 1 + DIV_STAGES + 1 + DIV_STAGES + 1;

    // Square root step widths
    localparam int SQ_REM_BITS = SAMPLE_BITS + 2;

    // Configuration register indexes
    localparam logic REG_INNER = 1'b0;
    localparam logic REG_OUTER = 1'b1;

    // Where the magnitude falls on the dead-zone map
    typedef enum logic [1:0] {
        C_NONE = 2'b00,
        C_FULL = 2'b01,
        C_RAMP = 2'b10
    } ckind_t;

    typedef struct packed {
        logic                   sx;
        logic                   sy;
        logic [SAMPLE_BITS-1:0] ax;
        logic [SAMPLE_BITS-1:0] ay;
    } axis_sb_t;

    typedef struct packed {
        axis_sb_t               axes;
        logic [SAMPLE_BITS-1:0] m;
        logic                   zero;
        ckind_t                 kind;
    } ramp_sb_t;

    typedef struct packed {
        logic                   sx;
        logic                   sy;
        logic [SAMPLE_BITS-1:0] c;
        logic                   zero;
    } scale_sb_t;

    typedef struct packed {
        logic [SQ_REM_BITS-1:0] rem;
        logic [SAMPLE_BITS-1:0] root;
        logic [SQ_BITS-1:0]     rad;
    } sqrt_st_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rem;
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] den;
        logic [SAMPLE_BITS-1:0] q;
    } div_st_t;

    // One digit of the restoring integer square root
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        logic [SQ_REM_BITS+1:0] t;
        logic [SQ_REM_BITS-1:0] trial;
        logic                   ge;
        sqrt_st_t               r;
        t     = {s.rem, s.rad[SQ_BITS-1 -: 2]};
        trial = {s.root, 2'b01};
        ge    = (t >= {2'b00, trial});
        r.rem  = ge ? SQ_REM_BITS'(t - {2'b00, trial}) : t[SQ_REM_BITS-1:0];
        r.root = {s.root[SAMPLE_BITS-2:0], ge};
        r.rad  = {s.rad[SQ_BITS-3:0], 2'b00};
        return r;
    endfunction

    // One quotient bit of restoring division
    function automatic div_st_t div_step(input div_st_t s);
        logic [SAMPLE_BITS:0] t;
        logic                 ge;
        div_st_t              r;
        t  = {s.rem, s.low[SAMPLE_BITS-1]};
        ge = (t >= {1'b0, s.den});
        r.rem = ge ? SAMPLE_BITS'(t - {1'b0, s.den}) : t[SAMPLE_BITS-1:0];
        r.low = {s.low[SAMPLE_BITS-2:0], 1'b0};
        r.den = s.den;
        r.q   = {s.q[SAMPLE_BITS-2:0], ge};
        return r;
    endfunction

endpackage

### src/jrd_isqrt.sv
module jrd_isqrt (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [jrd_pkg::SQ_BITS-1:0]         radicand,
    output logic [jrd_pkg::SAMPLE_BITS-1:0]     root
);

    jrd_pkg::sqrt_st_t st_reg [jrd_pkg::SQRT_STAGES];
    jrd_pkg::sqrt_st_t st_in;

    always_comb begin
        st_in.rem  = '0;
        st_in.root = '0;
        st_in.rad  = radicand;
    end

    // Resolve one root bit per stage
    for (genvar i = 0; i < jrd_pkg::SQRT_STAGES; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[i] <= jrd_pkg::sqrt_step(st_in);
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[i] <= jrd_pkg::sqrt_step(st_reg[i-1]);
                end
            end
        end
    end

    assign root = st_reg[jrd_pkg::SQRT_STAGES-1].root;

endmodule

### src/jrd_div.sv
module jrd_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [jrd_pkg::SQ_BITS-1:0]         dividend,
    input  logic [jrd_pkg::SAMPLE_BITS-1:0]     divisor,
    output logic [jrd_pkg::SAMPLE_BITS-1:0]     quotient
);

    // Upper half of the dividend must be below the divisor
    jrd_pkg::div_st_t st_reg [jrd_pkg::DIV_STAGES];
    jrd_pkg::div_st_t st_in;

    always_comb begin
        st_in.rem = dividend[jrd_pkg::SQ_BITS-1:jrd_pkg::SAMPLE_BITS];
        st_in.low = dividend[jrd_pkg::SAMPLE_BITS-1:0];
        st_in.den = divisor;
        st_in.q   = '0;
    end

    // Produce one quotient bit per stage
    for (genvar i = 0; i < jrd_pkg::DIV_STAGES; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[i] <= jrd_pkg::div_step(st_in);
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[i] <= jrd_pkg::div_step(st_reg[i-1]);
                end
            end
        end
    end

    assign quotient = st_reg[jrd_pkg::DIV_STAGES-1].q;

endmodule

### src/joystick_radial_deadzone_core.sv
// Radial inner/outer dead-zone correction for a two-axis stick in signed Q1.15.
// Each sample's length is taken as an exact integer square root, mapped
// linearly from [inner, outer] onto [0, 1.0] and clamped, and the sample is
// rescaled to that length in its own direction. One sample enters per clock
// while the output is not stalled. The pipeline holds the bit-per-stage square root (16 stages),
// the ramp divider (16 stages) and the axis rescaling dividers (16 stages). The
// whole pipeline holds while a result waits on m_tready. Write the dead-zone
// registers only while no transaction is in flight.
module joystick_radial_deadzone_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [jrd_pkg::SAMPLE_BITS-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*jrd_pkg::SAMPLE_BITS-1:0]   s_tdata,   // raw_x[15:0], raw_y[31:16]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [3*jrd_pkg::SAMPLE_BITS-1:0]   m_tdata    // corrected_x[15:0],
                                                           // corrected_y[31:16],
                                                           // corrected_magnitude[47:32]
);

    localparam int W = jrd_pkg::SAMPLE_BITS;
    localparam int D = jrd_pkg::PIPE_DEPTH;

    logic                 en;
    logic [D-1:0]         vld_reg;
    logic [D-1:0]         vld_next;
    logic [W-1:0]         inner_reg;
    logic [W-1:0]         outer_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg <= '0;
            outer_reg <= jrd_pkg::ONE_Q;
        end else if (cfg_we) begin
            case (cfg_index)
                jrd_pkg::REG_INNER: inner_reg <= cfg_wdata;
                jrd_pkg::REG_OUTER: outer_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance everything unless the output transaction is stalled
    assign en       = !vld_reg[D-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[D-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: absolute values and squares
    logic [W-1:0]              raw_x;
    logic [W-1:0]              raw_y;
    jrd_pkg::axis_sb_t         p1_sb;
    jrd_pkg::axis_sb_t         p1_reg;
    logic [2*W-1:0]            sqx_reg;
    logic [2*W-1:0]            sqy_reg;

    assign raw_x    = s_tdata[W-1:0];
    assign raw_y    = s_tdata[2*W-1:W];
    assign p1_sb.sx = raw_x[W-1];
    assign p1_sb.sy = raw_y[W-1];
    assign p1_sb.ax = raw_x[W-1] ? W'(-raw_x) : raw_x;
    assign p1_sb.ay = raw_y[W-1] ? W'(-raw_y) : raw_y;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= p1_sb;
            sqx_reg <= p1_sb.ax * p1_sb.ax;
            sqy_reg <= p1_sb.ay * p1_sb.ay;
        end
    end

    // Stage 2: sum of squares
    jrd_pkg::axis_sb_t p2_reg;
    logic [2*W-1:0]    sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg  <= p1_reg;
            sum_reg <= sqx_reg + sqy_reg;
        end
    end

    // Square root, with the axes carried alongside
    logic [W-1:0]      root;
    jrd_pkg::axis_sb_t sq_sb_reg [jrd_pkg::SQRT_STAGES];

    jrd_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_sb_reg[0] <= p2_reg;
            for (int i = 1; i < jrd_pkg::SQRT_STAGES; i++) begin
                sq_sb_reg[i] <= sq_sb_reg[i-1];
            end
        end
    end

    // Stage 3: place the magnitude on the dead-zone map
    jrd_pkg::ramp_sb_t p3_sb;
    jrd_pkg::ramp_sb_t p3_reg;
    logic [2*W-1:0]    num_reg;
    logic [W-1:0]      den_reg;
    logic [W-1:0]      diff;

    assign diff = root - inner_reg;

    always_comb begin
        p3_sb.axes = sq_sb_reg[jrd_pkg::SQRT_STAGES-1];
        p3_sb.m    = root;
        p3_sb.zero = (root == '0);
        if (outer_reg <= inner_reg) begin
            p3_sb.kind = (root > inner_reg) ? jrd_pkg::C_FULL : jrd_pkg::C_NONE;
        end else if (root <= inner_reg) begin
            p3_sb.kind = jrd_pkg::C_NONE;
        end else if (root >= outer_reg) begin
            p3_sb.kind = jrd_pkg::C_FULL;
        end else begin
            p3_sb.kind = jrd_pkg::C_RAMP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_reg  <= p3_sb;
            num_reg <= (p3_sb.kind == jrd_pkg::C_RAMP)
                       ? ((2*W)'(diff) << jrd_pkg::FRAC_BITS) : '0;
            den_reg <= outer_reg - inner_reg;
        end
    end

    // Ramp divider
    logic [W-1:0]      ramp_q;
    jrd_pkg::ramp_sb_t d1_sb_reg [jrd_pkg::DIV_STAGES];

    jrd_div u_div_ramp (
        .aclk     (aclk),
        .en       (en),
        .dividend (num_reg),
        .divisor  (den_reg),
        .quotient (ramp_q)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_sb_reg[0] <= p3_reg;
            for (int i = 1; i < jrd_pkg::DIV_STAGES; i++) begin
                d1_sb_reg[i] <= d1_sb_reg[i-1];
            end
        end
    end

    // Stage 4: corrected length and scaled axes
    jrd_pkg::ramp_sb_t  d1_out;
    logic [W-1:0]       c_val;
    jrd_pkg::scale_sb_t p4_reg;
    logic [2*W-1:0]     px_reg;
    logic [2*W-1:0]     py_reg;
    logic [W-1:0]       m4_reg;

    assign d1_out = d1_sb_reg[jrd_pkg::DIV_STAGES-1];

    always_comb begin
        case (d1_out.kind)
            jrd_pkg::C_FULL: c_val = jrd_pkg::ONE_Q;
            jrd_pkg::C_RAMP: c_val = ramp_q;
            default:         c_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_reg.sx   <= d1_out.axes.sx;
            p4_reg.sy   <= d1_out.axes.sy;
            p4_reg.c    <= c_val;
            p4_reg.zero <= d1_out.zero;
            px_reg      <= d1_out.axes.ax * c_val;
            py_reg      <= d1_out.axes.ay * c_val;
            m4_reg      <= d1_out.m;
        end
    end

    // Axis rescaling dividers
    logic [W-1:0]       qx;
    logic [W-1:0]       qy;
    jrd_pkg::scale_sb_t d2_sb_reg [jrd_pkg::DIV_STAGES];

    jrd_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .dividend (px_reg),
        .divisor  (m4_reg),
        .quotient (qx)
    );

    jrd_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .dividend (py_reg),
        .divisor  (m4_reg),
        .quotient (qy)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_sb_reg[0] <= p4_reg;
            for (int i = 1; i < jrd_pkg::DIV_STAGES; i++) begin
                d2_sb_reg[i] <= d2_sb_reg[i-1];
            end
        end
    end

    // Output stage: saturate, restore sign, zero a null vector
    jrd_pkg::scale_sb_t d2_out;
    logic [W-1:0]       sat_x;
    logic [W-1:0]       sat_y;
    logic [W-1:0]       out_x_reg;
    logic [W-1:0]       out_y_reg;
    logic [W-1:0]       out_c_reg;

    assign d2_out = d2_sb_reg[jrd_pkg::DIV_STAGES-1];
    assign sat_x  = (qx > jrd_pkg::MAX_POS) ? jrd_pkg::MAX_POS : qx;
    assign sat_y  = (qy > jrd_pkg::MAX_POS) ? jrd_pkg::MAX_POS : qy;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (d2_out.zero) begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_c_reg <= '0;
            end else begin
                out_x_reg <= d2_out.sx ? W'(-sat_x) : sat_x;
                out_y_reg <= d2_out.sy ? W'(-sat_y) : sat_y;
                out_c_reg <= d2_out.c;
            end
        end
    end

    assign m_tvalid = vld_reg[D-1];
    assign m_tdata  = {out_c_reg, out_y_reg, out_x_reg};

    // Checks
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_c_reg <= jrd_pkg::ONE_Q))
        else $error("corrected magnitude above full scale");

    a_zero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_c_reg == '0) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("non-zero axis with zero magnitude");

    a_axis_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_x_reg != jrd_pkg::ONE_Q && out_y_reg != jrd_pkg::ONE_Q))
        else $error("axis escaped saturation");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cmag;
    } corr_t;

    localparam int QUIET_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // raw_x[15:0], raw_y[31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // corrected_x[15:0], corrected_y[31:16],
                             // corrected_magnitude[47:32]

    logic [31:0] sample_q[$];
    corr_t       corr_q[$];
    logic [15:0] inner_r;
    logic [15:0] outer_r;
    int          send_idle;
    int          recv_idle;
    bit          hold_send;
    bit          in_taken;
    int          failures;
    int          quiet;

    joystick_radial_deadzone_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Exact integer square root, bit by bit
    function automatic longint unsigned root_of(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] rescale_axis(input logic signed [15:0] a,
                                                 input longint unsigned c,
                                                 input longint unsigned m);
        longint unsigned mag;
        longint unsigned q;
        mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
        q = (mag * c) / m;
        if (q > 32767) q = 32767;
        if (a < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic corr_t deadzone_correct(input logic [31:0] raw);
        logic signed [15:0] x;
        logic signed [15:0] y;
        longint unsigned    ax;
        longint unsigned    ay;
        longint unsigned    m;
        longint unsigned    c;
        corr_t              r;
        x = raw[15:0];
        y = raw[31:16];
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        m = root_of(ax * ax + ay * ay);
        r = '0;
        if (m == 0) return r;
        if (outer_r <= inner_r) c = (m > inner_r) ? 32768 : 0;
        else if (m <= inner_r) c = 0;
        else if (m >= outer_r) c = 32768;
        else c = ((m - inner_r) << 15) / (outer_r - inner_r);
        r.cx = rescale_axis(x, c, m);
        r.cy = rescale_axis(y, c, m);
        r.cmag = c[15:0];
        return r;
    endfunction

    // Drive one sample per transaction, idling at random, and randomize m_tready
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (sample_q.size() != 0 && !hold_send &&
                $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q[0];
                corr_q.push_back(deadzone_correct(sample_q[0]));
                sample_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Check each result transaction against the oldest prediction
    always @(posedge aclk) begin
        corr_t got;
        corr_t want;
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
            end
            if (m_tvalid && m_tready) begin
                got.cx   = m_tdata[15:0];
                got.cy   = m_tdata[31:16];
                got.cmag = m_tdata[47:32];
                if (corr_q.size() == 0) begin
                    $error("result with no prediction waiting");
                    failures++;
                end else begin
                    want = corr_q.pop_front();
                    if (got.cx !== want.cx) begin
                        $error("corrected_x exp %0d got %0d", $signed(want.cx), $signed(got.cx));
                        failures++;
                    end
                    if (got.cy !== want.cy) begin
                        $error("corrected_y exp %0d got %0d", $signed(want.cy), $signed(got.cy));
                        failures++;
                    end
                    if (got.cmag !== want.cmag) begin
                        $error("corrected_magnitude exp %0d got %0d", want.cmag, got.cmag);
                        failures++;
                    end
                end
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (sample_q.size() != 0 || corr_q.size() != 0 || s_tvalid) @(posedge aclk);
        repeat (jrd_pkg::PIPE_DEPTH + 10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == jrd_pkg::REG_INNER) inner_r = val;
        if (idx == jrd_pkg::REG_OUTER) outer_r = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic load_random(input int n);
        repeat (n) sample_q.push_back({pick_axis(), pick_axis()});
    endtask

    initial begin
        logic [15:0] inner_set[6];
        logic [15:0] outer_set[6];
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = jrd_pkg::REG_INNER; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        inner_r = 16'd0; outer_r = 16'd32768;
        send_idle = 36; recv_idle = 78;
        hold_send = 1'b0; in_taken = 1'b0; failures = 0; quiet = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: axis extremes, zero length, full deflection at reset map
        sample_q.push_back({16'h0000, 16'h0000});
        sample_q.push_back({16'h0000, 16'h7fff});
        sample_q.push_back({16'h8000, 16'h0000});
        sample_q.push_back({16'h8000, 16'h8000});
        sample_q.push_back({16'h7fff, 16'h7fff});
        sample_q.push_back({16'hffff, 16'h0001});
        sample_q.push_back({16'h4000, 16'hc000});
        sample_q.push_back({16'h0003, 16'h0004});
        sample_q.push_back({16'h5555, 16'haaaa});
        wait_drained();
        // Ramp, then step with equal radii, including a length above one
        write_reg(jrd_pkg::REG_INNER, 16'd8000);
        write_reg(jrd_pkg::REG_OUTER, 16'd24000);
        sample_q.push_back({16'h0000, 16'd8000});
        sample_q.push_back({16'h0000, 16'd8001});
        sample_q.push_back({16'd24000, 16'h0000});
        sample_q.push_back({16'h2000, 16'h3000});
        wait_drained();
        write_reg(jrd_pkg::REG_OUTER, 16'd8000);
        sample_q.push_back({16'h0000, 16'd8000});
        sample_q.push_back({16'h0000, 16'd8001});
        sample_q.push_back({16'h8000, 16'h8000});
        wait_drained();

        // Hold off the sender until every prediction has been met
        load_random(30);
        while (corr_q.size() < 20 && sample_q.size() != 0) @(posedge aclk);
        hold_send = 1'b1;
        while (corr_q.size() != 0) @(posedge aclk);
        hold_send = 1'b0;

        inner_set = '{16'd0, 16'd32768, 16'd3000, 16'd65535, 16'd20000, 16'd1000};
        outer_set = '{16'd32768, 16'd0, 16'd30000, 16'd65535, 16'd20000, 16'd46000};
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph == 2) begin
                send_idle = 78; recv_idle = 36;
            end else if (ph == 4) begin
                send_idle = 0; recv_idle = 0;
            end
            write_reg(jrd_pkg::REG_INNER, inner_set[ph]);
            write_reg(jrd_pkg::REG_OUTER, outer_set[ph]);
            load_random(260);
        end
        wait_drained();

        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### files.f
src/jrd_pkg.sv
src/jrd_isqrt.sv
src/jrd_div.sv
src/joystick_radial_deadzone_core.sv
tb/testbench.sv
